// ===== design/mwra_pkg.sv =====
package mwra_pkg;

  // widths fixed by the item formats
  localparam int unsigned SUM_W  = 64;
  localparam int unsigned WTOT_W = 40;
  localparam int unsigned PROD_W = 49;
  localparam int unsigned ID_W   = 4;
  localparam int unsigned MAX_REGIONS = 16;

  // configuration register indexes
  typedef enum logic [0:0] {
    CFG_USE_WEIGHT = 1'b0,
    CFG_AVG_ENABLE = 1'b1
  } cfg_idx_t;

  // per-region contents held by one cell
  typedef struct packed {
    logic [SUM_W-1:0]  sum;
    logic [WTOT_W-1:0] wtot;
    logic              seen;
  } cell_data_t;

  // control broadcast to every cell
  typedef struct packed {
    logic acc;
    logic shift;
    logic clr;
  } cell_ctl_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ACC,
    ST_EMIT,
    ST_DIV,
    ST_OUT
  } state_t;

endpackage

// ===== design/masked_weighted_region_average_core.sv =====
// Masked weighted region average.
// Input channel in_*: one sample per item. in_tdata holds field_value (Q16.16),
// mask_value and weight; in_tlast marks the last sample of a frame.
// Each sample passes a product register, then the region's cell does a
// saturating add of value*weight and of the weight.
// On a last sample the cell chain shifts toward its head, one region per cycle
// while no result is held in the divider or output; each seen region gives one
// item on out_*: out_tdata holds region_id and region_result, out_tuser is
// zero_weight, out_tlast marks the frame's final result. With averaging on and a
// nonzero weight total, a result passes through a bit-serial divider, else it goes
// straight to the output register. A frame ends with an all-cell clear.
// The output register holds its item while out_tready is low; no new sample
// is taken until the frame's results have all been delivered.
// Reset (rst_n low, synchronous) clears the store, use_weight to 0 and
// average_enable to 1. Configuration writes via cfg_we/cfg_addr/cfg_wdata.
module masked_weighted_region_average_core #(
  parameter int REGION_COUNT = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [55:0] in_tdata,   // [31:0] field_value, [35:32] mask_value, [51:36] weight
  input  logic        in_tlast,   // last_sample
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [71:0] out_tdata,  // [3:0] region_id, [67:4] region_result
  output logic        out_tuser,  // zero_weight
  output logic        out_tlast,  // last_result
  input  logic        cfg_we,
  input  logic        cfg_addr,
  input  logic        cfg_wdata
);

  localparam int NREG = (REGION_COUNT < mwra_pkg::MAX_REGIONS) ? REGION_COUNT
                                                               : mwra_pkg::MAX_REGIONS;

  mwra_pkg::state_t     state_r, state_nxt;
  mwra_pkg::cell_ctl_t  ctl;
  mwra_pkg::cell_data_t chain [NREG+1];
  logic [NREG-1:0]      seen_vec;

  logic use_weight_r, avg_enable_r;
  logic signed [mwra_pkg::PROD_W-1:0] prod_r;
  logic [15:0]                 wt_r;
  logic [mwra_pkg::ID_W-1:0]   region_r, idx_r, idx_nxt;
  logic                        last_r;
  logic [mwra_pkg::ID_W-1:0]   o_id_r, o_id_nxt;
  logic [mwra_pkg::SUM_W-1:0]  o_res_r, o_res_nxt;
  logic                        o_zw_r, o_zw_nxt, o_last_r, o_last_nxt;
  logic                        any_tail, div_start, div_busy, div_done;
  logic [mwra_pkg::SUM_W-1:0]  div_quot;
  logic [15:0]                 w_eff;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      use_weight_r <= 1'b0;
      avg_enable_r <= 1'b1;
    end else if (cfg_we) begin
      unique case (mwra_pkg::cfg_idx_t'(cfg_addr))
        mwra_pkg::CFG_USE_WEIGHT: use_weight_r <= cfg_wdata;
        mwra_pkg::CFG_AVG_ENABLE: avg_enable_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // product stage
  assign w_eff = use_weight_r ? in_tdata[51:36] : 16'd1;
  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      prod_r   <= $signed(in_tdata[31:0]) * $signed({1'b0, w_eff});
      wt_r     <= w_eff;
      region_r <= in_tdata[35:32];
      last_r   <= in_tlast;
    end
  end

  // cell chain, head is cell 0
  assign chain[NREG] = '0;
  for (genvar i = 0; i < NREG; i++) begin : g_cell
    mwra_cell #(.CELL_IDX(i)) u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .ctl      (ctl),
      .region   (region_r),
      .prod     (prod_r),
      .wt       (wt_r),
      .nb_in    (chain[i+1]),
      .data_out (chain[i])
    );
    assign seen_vec[i] = chain[i].seen;
  end

  assign any_tail = |(seen_vec >> 1);

  mwra_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (chain[0].sum),
    .divisor  (chain[0].wtot),
    .busy     (div_busy),
    .done     (div_done),
    .quot     (div_quot)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= mwra_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    idx_r    <= idx_nxt;
    o_id_r   <= o_id_nxt;
    o_res_r  <= o_res_nxt;
    o_zw_r   <= o_zw_nxt;
    o_last_r <= o_last_nxt;
  end

  // sequencer: accumulate, then walk the chain and emit seen regions
  always_comb begin
    state_nxt  = state_r;
    ctl        = '0;
    idx_nxt    = idx_r;
    o_id_nxt   = o_id_r;
    o_res_nxt  = o_res_r;
    o_zw_nxt   = o_zw_r;
    o_last_nxt = o_last_r;
    div_start  = 1'b0;
    in_tready  = 1'b0;
    out_tvalid = 1'b0;
    unique case (state_r)
      mwra_pkg::ST_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) state_nxt = mwra_pkg::ST_ACC;
      end
      mwra_pkg::ST_ACC: begin
        ctl.acc = 1'b1;
        idx_nxt = '0;
        state_nxt = last_r ? mwra_pkg::ST_EMIT : mwra_pkg::ST_IDLE;
      end
      mwra_pkg::ST_EMIT: begin
        if (chain[0].seen) begin
          o_id_nxt   = idx_r;
          o_last_nxt = !any_tail;
          o_zw_nxt   = 1'b0;
          if (!avg_enable_r) begin
            o_res_nxt = chain[0].sum;
            state_nxt = mwra_pkg::ST_OUT;
            ctl.shift = 1'b1;
            idx_nxt   = idx_r + 1'b1;
          end else if (chain[0].wtot == '0) begin
            o_res_nxt = '0;
            o_zw_nxt  = 1'b1;
            state_nxt = mwra_pkg::ST_OUT;
            ctl.shift = 1'b1;
            idx_nxt   = idx_r + 1'b1;
          end else begin
            div_start = 1'b1;
            state_nxt = mwra_pkg::ST_DIV;
          end
        end else if (any_tail) begin
          ctl.shift = 1'b1;
          idx_nxt   = idx_r + 1'b1;
        end else begin
          ctl.clr   = 1'b1;
          state_nxt = mwra_pkg::ST_IDLE;
        end
      end
      mwra_pkg::ST_DIV: begin
        if (div_done) begin
          o_res_nxt = div_quot;
          ctl.shift = 1'b1;
          idx_nxt   = idx_r + 1'b1;
          state_nxt = mwra_pkg::ST_OUT;
        end
      end
      mwra_pkg::ST_OUT: begin
        out_tvalid = 1'b1;
        if (out_tready) state_nxt = mwra_pkg::ST_EMIT;
      end
      default: state_nxt = mwra_pkg::ST_IDLE;
    endcase
  end

  assign out_tdata = {4'd0, o_res_r, o_id_r};
  assign out_tuser = o_zw_r;
  assign out_tlast = o_last_r;

`ifndef SYNTHESIS
  // divider only runs while a result is being computed
  a_div_in_div: assert property (@(posedge clk) disable iff (!rst_n)
    div_busy |-> (state_r == mwra_pkg::ST_DIV))
    else $error("divider busy outside division state");

  // clearing the chain leaves no region marked seen
  a_clear_empty: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.clr |=> (seen_vec == '0))
    else $error("store not empty after clear");

  // a finished frame ends on a final-result item before accepting samples again
  a_last_before_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tready && !out_tlast) |=> (state_r == mwra_pkg::ST_EMIT && any_tail)
      || (state_r == mwra_pkg::ST_EMIT && seen_vec[0]))
    else $error("non-final result with no region left");
`endif

endmodule

// ===== design/mwra_cell.sv =====
module mwra_cell #(
  parameter int CELL_IDX = 0
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  mwra_pkg::cell_ctl_t                ctl,
  input  logic [mwra_pkg::ID_W-1:0]          region,
  input  logic signed [mwra_pkg::PROD_W-1:0] prod,
  input  logic [15:0]                        wt,
  input  mwra_pkg::cell_data_t               nb_in,
  output mwra_pkg::cell_data_t               data_out
);

  mwra_pkg::cell_data_t data_r, data_nxt;
  logic [mwra_pkg::SUM_W:0]  sum_ext;
  logic [mwra_pkg::WTOT_W:0] wtot_ext;
  logic                      hit;

  assign hit = (region == mwra_pkg::ID_W'(CELL_IDX));

  // clear, else shift in from the neighbour, else saturating accumulate of value*weight and weight
  always_comb begin
    sum_ext  = {data_r.sum[mwra_pkg::SUM_W-1], data_r.sum}
             + {{(mwra_pkg::SUM_W+1-mwra_pkg::PROD_W){prod[mwra_pkg::PROD_W-1]}}, prod};
    wtot_ext = {1'b0, data_r.wtot} + {{(mwra_pkg::WTOT_W-15){1'b0}}, wt};
    data_nxt = data_r;
    if (ctl.clr) begin
      data_nxt = '0;
    end else if (ctl.shift) begin
      data_nxt = nb_in;
    end else if (ctl.acc && hit) begin
      if (sum_ext[mwra_pkg::SUM_W] != sum_ext[mwra_pkg::SUM_W-1]) begin
        data_nxt.sum = sum_ext[mwra_pkg::SUM_W] ? {1'b1, {(mwra_pkg::SUM_W-1){1'b0}}}
                                                : {1'b0, {(mwra_pkg::SUM_W-1){1'b1}}};
      end else begin
        data_nxt.sum = sum_ext[mwra_pkg::SUM_W-1:0];
      end
      data_nxt.wtot = wtot_ext[mwra_pkg::WTOT_W] ? '1 : wtot_ext[mwra_pkg::WTOT_W-1:0];
      data_nxt.seen = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      data_r <= '0;
    end else begin
      data_r <= data_nxt;
    end
  end

  assign data_out = data_r;

endmodule

// ===== design/mwra_div.sv =====
module mwra_div (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               start,
  input  logic [mwra_pkg::SUM_W-1:0]         dividend,
  input  logic [mwra_pkg::WTOT_W-1:0]        divisor,
  output logic                               busy,
  output logic                               done,
  output logic [mwra_pkg::SUM_W-1:0]         quot
);

  logic                        busy_r, busy_nxt, done_r, done_nxt, neg_r, neg_nxt;
  logic [5:0]                  cnt_r, cnt_nxt;
  logic [mwra_pkg::SUM_W-1:0]  q_r, q_nxt;
  logic [mwra_pkg::WTOT_W-1:0] rem_r, rem_nxt, d_r, d_nxt;
  logic [mwra_pkg::WTOT_W:0]   trial;

  function automatic logic [mwra_pkg::WTOT_W-1:0] WTOT_SEL(input logic [mwra_pkg::WTOT_W:0] v);
    return v[mwra_pkg::WTOT_W-1:0];
  endfunction

  // restoring division, one quotient bit per cycle on the magnitude
  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    neg_nxt  = neg_r;
    cnt_nxt  = cnt_r;
    q_nxt    = q_r;
    rem_nxt  = rem_r;
    d_nxt    = d_r;
    trial    = {rem_r, q_r[mwra_pkg::SUM_W-1]};
    if (start) begin
      busy_nxt = 1'b1;
      neg_nxt  = dividend[mwra_pkg::SUM_W-1];
      q_nxt    = dividend[mwra_pkg::SUM_W-1] ? (~dividend + 1'b1) : dividend;
      rem_nxt  = '0;
      d_nxt    = divisor;
      cnt_nxt  = '0;
    end else if (busy_r) begin
      if (trial >= {1'b0, d_r}) begin
        rem_nxt = WTOT_SEL(trial - {1'b0, d_r});
        q_nxt   = {q_r[mwra_pkg::SUM_W-2:0], 1'b1};
      end else begin
        rem_nxt = WTOT_SEL(trial);
        q_nxt   = {q_r[mwra_pkg::SUM_W-2:0], 1'b0};
      end
      cnt_nxt = cnt_r + 6'd1;
      if (cnt_r == 6'd63) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    neg_r <= neg_nxt;
    q_r   <= q_nxt;
    rem_r <= rem_nxt;
    d_r   <= d_nxt;
  end

  assign busy = busy_r;
  assign done = done_r;
  assign quot = neg_r ? (~q_r + 1'b1) : q_r;

endmodule

// ===== sim/masked_weighted_region_average_core_tb.sv =====
module masked_weighted_region_average_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NREG = 16;
  localparam logic [39:0] WTOT_MAX = 40'hFF_FFFF_FFFF;
  localparam int STALL_LIMIT = 20000;

  typedef struct packed {
    logic [3:0]  id;
    logic [63:0] value;
    logic        zw;
    logic        last;
  } region_res_t;

  // region accumulator model plus queue of expected region results
  class region_scoreboard;
    logic signed [63:0] wsum[NREG];
    logic [39:0]        wtot[NREG];
    bit                 seen[NREG];
    bit                 use_w;
    bit                 avg_en;
    region_res_t        pending[$];
    int                 errors;

    function new();
      use_w = 0;
      avg_en = 1;
      errors = 0;
      clear();
    endfunction

    function void clear();
      for (int r = 0; r < NREG; r++) begin
        wsum[r] = '0;
        wtot[r] = '0;
        seen[r] = 0;
      end
    endfunction

    // accumulate one sample; on the last one queue the frame's results
    function void note_sample(logic signed [31:0] fv, logic [3:0] reg_id,
                              logic [15:0] w_in, bit last);
      logic [15:0]        w;
      logic signed [64:0] s;
      logic [40:0]        t;
      int                 last_r;
      region_res_t        e;
      logic [63:0]        mag;
      logic [63:0]        q;
      w = use_w ? w_in : 16'd1;
      s = $signed(wsum[reg_id]) + ($signed(fv) * $signed({1'b0, w}));
      if (s > 65'sh0_7FFF_FFFF_FFFF_FFFF) wsum[reg_id] = 64'sh7FFF_FFFF_FFFF_FFFF;
      else if (s < -65'sh0_8000_0000_0000_0000) wsum[reg_id] = 64'sh8000_0000_0000_0000;
      else wsum[reg_id] = s[63:0];
      t = wtot[reg_id] + w;
      wtot[reg_id] = (t > WTOT_MAX) ? WTOT_MAX : t[39:0];
      seen[reg_id] = 1;
      if (!last) return;
      last_r = -1;
      for (int r = 0; r < NREG; r++) if (seen[r]) last_r = r;
      for (int r = 0; r < NREG; r++) begin
        if (!seen[r]) continue;
        e.id = r[3:0];
        e.zw = 0;
        e.last = (r == last_r);
        if (!avg_en) e.value = wsum[r];
        else if (wtot[r] == 0) begin
          e.value = '0;
          e.zw = 1;
        end else begin
          mag = wsum[r][63] ? -wsum[r] : wsum[r];
          q = mag / {24'd0, wtot[r]};
          e.value = wsum[r][63] ? -q : q;
        end
        pending = {pending, e};
      end
      clear();
    endfunction

    function void check_result(region_res_t got);
      region_res_t e;
      if (pending.size() == 0) begin
        $error("unexpected result id=%0d value=%h", got.id, got.value);
        errors++;
        return;
      end
      e = pending.pop_front();
      if (got.id !== e.id) begin
        $error("region_id exp %0d got %0d", e.id, got.id); errors++;
      end
      if (got.value !== e.value) begin
        $error("region_result exp %h got %h", e.value, got.value); errors++;
      end
      if (got.zw !== e.zw) begin
        $error("zero_weight exp %0b got %0b", e.zw, got.zw); errors++;
      end
      if (got.last !== e.last) begin
        $error("last_result exp %0b got %0b", e.last, got.last); errors++;
      end
    endfunction
  endclass

  logic        clk = 0;
  logic        rst_n = 0;
  logic        in_tvalid = 0;
  logic        in_tready;
  logic [55:0] in_tdata = '0;  // [31:0] field_value, [35:32] mask_value, [51:36] weight
  logic        in_tlast = 0;   // last_sample
  logic        out_tvalid;
  logic        out_tready = 0;
  logic [71:0] out_tdata;      // [3:0] region_id, [67:4] region_result
  logic        out_tuser;      // zero_weight
  logic        out_tlast;      // last_result
  logic        cfg_we = 0;
  logic        cfg_addr = 0;
  logic        cfg_wdata = 0;

  region_scoreboard sb = new();
  int  idle_cycles = 0;
  bit  hold_long = 0;
  bit  out_gaps = 1;

  always begin
    #2 clk = 1;
    #2 clk = 0;
  end

  masked_weighted_region_average_core #(.REGION_COUNT(NREG)) i_dut (.*);

  // accepted items on both channels, plus stall watchdog
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_tvalid && out_tready)
        sb.check_result('{out_tdata[3:0], out_tdata[67:4], out_tuser, out_tlast});
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles > STALL_LIMIT) begin
        $display("simulation failed");
        $finish;
      end
    end
  end

  // receiver: random stalls or always ready, or one long hold-off on request
  always @(posedge clk) begin
    if (hold_long) out_tready <= 0;
    else if (!out_gaps) out_tready <= 1;
    else if ($urandom_range(0, 9) < 7) out_tready <= 1;
    else out_tready <= 0;
  end

  task automatic hold_receiver();
    hold_long = 1;
    repeat (400) @(posedge clk);
    hold_long = 0;
  endtask

  task automatic idle_gap(bit gaps);
    int n;
    if (!gaps) return;
    n = ($urandom_range(0, 19) == 0) ? $urandom_range(10, 40) : $urandom_range(0, 2);
    repeat (n) @(posedge clk);
  endtask

  task automatic send_sample(logic [31:0] fv, logic [3:0] rid, logic [15:0] w, bit last,
                             bit gaps);
    idle_gap(gaps);
    in_tvalid <= 1;
    in_tdata <= {4'd0, w, rid, fv};
    in_tlast <= last;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    sb.note_sample(fv, rid, w, last);
    in_tvalid <= 0;
    @(posedge clk);
  endtask

  task automatic drain();
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (80) @(posedge clk);
  endtask

  task automatic write_cfg(mwra_pkg::cfg_idx_t idx, bit val);
    cfg_we <= 1;
    cfg_addr <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 0;
    if (idx == mwra_pkg::CFG_USE_WEIGHT) sb.use_w = val;
    else sb.avg_en = val;
    @(posedge clk);
  endtask

  // a frame of random samples over all regions, sometimes extreme values and weights
  task automatic random_frame(int len, bit gaps);
    logic [31:0] fv;
    logic [15:0] w;
    for (int i = 0; i < len; i++) begin
      case ($urandom_range(0, 5))
        0: fv = 32'h7FFF_FFFF;
        1: fv = 32'h8000_0000;
        default: fv = $urandom;
      endcase
      w = ($urandom_range(0, 4) == 0) ? 16'hFFFF :
          ($urandom_range(0, 5) == 0) ? 16'd0 : 16'($urandom);
      send_sample(fv, 4'($urandom_range(0, 15)), w, i == len - 1, gaps);
    end
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    // reset config: no weights, averaging on
    send_sample(32'h0001_0000, 4'd3, 16'd9, 0, 0);
    send_sample(32'hFFFF_0000, 4'd3, 16'd9, 0, 0);
    send_sample(32'h7FFF_FFFF, 4'd15, 16'hFFFF, 0, 0);
    send_sample(32'h8000_0000, 4'd0, 16'd0, 1, 0);
    drain();
    // last sample with nothing else: one region
    send_sample(32'h0000_0005, 4'd7, 16'd1, 1, 0);
    drain();

    // weights on, integral mode; zero weight average case
    write_cfg(mwra_pkg::CFG_USE_WEIGHT, 1);
    write_cfg(mwra_pkg::CFG_AVG_ENABLE, 0);
    for (int r = 0; r < 16; r++)
      send_sample(r[0] ? 32'h7FFF_FFFF : 32'h8000_0000, r[3:0], 16'hFFFF, 0, 0);
    send_sample(32'h1234_5678, 4'd5, 16'hA5A5, 1, 0);
    drain();
    write_cfg(mwra_pkg::CFG_AVG_ENABLE, 1);
    send_sample(32'h0003_0000, 4'd2, 16'd0, 0, 0);
    send_sample(32'hFFFF_FFFF, 4'd9, 16'd3, 1, 0);
    drain();

    // long receiver hold-off in integral mode while frames keep coming
    write_cfg(mwra_pkg::CFG_AVG_ENABLE, 0);
    hold_receiver_fill();
    drain();

    // random frames across all settings
    for (int f = 0; f < 30; f++) begin
      write_cfg(mwra_pkg::CFG_USE_WEIGHT, $urandom_range(0, 1));
      write_cfg(mwra_pkg::CFG_AVG_ENABLE, $urandom_range(0, 1));
      out_gaps = ($urandom_range(0, 3) != 0);
      random_frame($urandom_range(1, 14), $urandom_range(0, 3) != 0);
      drain();
    end
    drain();

    if (sb.errors == 0) $display("simulation ok");
    else $display("simulation failed");
    $finish;
  end

  // long receiver hold-off while the sender keeps offering frames
  task automatic hold_receiver_fill();
    fork
      hold_receiver();
      begin
        for (int k = 0; k < 3; k++) random_frame(4, 0);
      end
    join
  endtask

endmodule

// ===== masked_weighted_region_average_core.f =====
design/mwra_pkg.sv
design/mwra_cell.sv
design/mwra_div.sv
design/masked_weighted_region_average_core.sv
sim/masked_weighted_region_average_core_tb.sv
